// ===== sv/serial_line_assembler_top_macros.svh =====
// assertion macros shared by the serial line assembler modules
// expects clk and rst_n in the scope of each use
`ifndef SERIAL_LINE_ASSEMBLER_TOP_MACROS_SVH
`define SERIAL_LINE_ASSEMBLER_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SLA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("serial line assembler check failed");

// implication checked on every rising clock edge outside reset
`define SLA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serial line assembler check failed");

`endif

// ===== sv/sla_pkg.sv =====
// types and constants of the serial line assembler
// no dependencies
package sla_pkg;

  // character codes
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 1'b1;

  localparam logic [15:0] MAX_LEN_RST = 16'd64;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_EOL  = 1'b1
  } out_kind_t;

  typedef enum logic [1:0] {
    REASON_LF       = 2'd0,
    REASON_OVERFLOW = 2'd1,
    REASON_TIMEOUT  = 2'd2
  } end_reason_t;

  // one result item
  typedef struct packed {
    out_kind_t   kind;
    logic [7:0]  char_byte;
    logic [15:0] char_index;
    logic [15:0] line_length;
    end_reason_t reason;
    logic        is_last;
  } sla_result_t;

  // results caused by one accepted item, in order
  typedef struct packed {
    logic        push0;
    logic        push1;
    sla_result_t res0;
    sla_result_t res1;
  } sla_push_t;

endpackage

// ===== sv/sla_core.sv =====
// line state, configuration registers and result generation
// depends on sla_pkg and serial_line_assembler_top_macros.svh
`include "serial_line_assembler_top_macros.svh"
module sla_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sla_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           acc,
  input  logic                           req_type,
  input  logic [7:0]                     rx_byte,
  output sla_pkg::sla_push_t             push
);
  import sla_pkg::*;

  logic [15:0] max_len_r, max_len_nxt;
  logic [31:0] timeout_r, timeout_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] idle_r, idle_nxt;
  logic        drop_r, drop_nxt;

  logic [15:0] limit;
  logic [15:0] count_inc;
  logic [31:0] idle_inc;
  sla_result_t eol_res;
  sla_result_t char_res;

  // overflow limit, small sizes act as two
  assign limit     = (max_len_r < 16'd2) ? 16'd1 : max_len_r - 16'd1;
  assign count_inc = count_r + 16'd1;
  assign idle_inc  = (idle_r == 32'hffff_ffff) ? idle_r : idle_r + 32'd1;

  // configuration writes
  always_comb begin
    max_len_nxt = max_len_r;
    timeout_nxt = timeout_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LEN:    max_len_nxt = cfg_data[15:0];
        REG_TIMEOUT_MS: timeout_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // line state update and results for the accepted item
  always_comb begin
    count_nxt = count_r;
    idle_nxt  = idle_r;
    drop_nxt  = drop_r;
    push      = '0;

    char_res             = '0;
    char_res.kind        = KIND_CHAR;
    char_res.char_byte   = rx_byte;
    char_res.char_index  = count_r;
    char_res.is_last     = 1'b1;

    eol_res              = '0;
    eol_res.kind         = KIND_EOL;
    eol_res.line_length  = count_r;
    eol_res.reason       = REASON_LF;
    eol_res.is_last      = 1'b1;

    if (acc) begin
      if (req_type == REQ_TICK) begin
        if (timeout_r != 32'd0 && idle_inc >= timeout_r) begin
          eol_res.reason = REASON_TIMEOUT;
          push.push0     = 1'b1;
          push.res0      = eol_res;
          count_nxt      = '0;
          idle_nxt       = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end else if (drop_r) begin
        drop_nxt = 1'b0;
      end else if (rx_byte == CH_CR) begin
        // carriage return is ignored
      end else if (rx_byte == CH_LF) begin
        push.push0 = 1'b1;
        push.res0  = eol_res;
        count_nxt  = '0;
        idle_nxt   = '0;
      end else begin
        push.push0 = 1'b1;
        push.res0  = char_res;
        count_nxt  = count_inc;
        idle_nxt   = '0;
        if (count_inc >= limit) begin
          // overflow: character then end of line
          push.res0.is_last   = 1'b0;
          eol_res.reason      = REASON_OVERFLOW;
          eol_res.line_length = count_inc;
          push.push1          = 1'b1;
          push.res1           = eol_res;
          drop_nxt            = 1'b1;
          count_nxt           = '0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      timeout_r <= '0;
      count_r   <= '0;
      idle_r    <= '0;
      drop_r    <= 1'b0;
    end else begin
      max_len_r <= max_len_nxt;
      timeout_r <= timeout_nxt;
      count_r   <= count_nxt;
      idle_r    <= idle_nxt;
      drop_r    <= drop_nxt;
    end
  end

  // checks
  `SLA_ASSERT_IMP(a_push1_needs_push0, push.push1, push.push0)
  `SLA_ASSERT_IMP(a_overflow_sets_drop, push.push1, ##1 (drop_r && count_r == 16'd0))
  `SLA_ASSERT_IMP(a_eol_clears_idle, push.push0 && push.res0.kind == KIND_EOL,
                  ##1 (idle_r == 32'd0 && count_r == 16'd0))
  `SLA_ASSERT_IMP(a_drop_only_after_overflow, $rose(drop_r), $past(push.push1))

endmodule

// ===== sv/sla_fifo.sv =====
// four-entry result queue, takes up to two results a cycle, gives one
// depends on sla_pkg and serial_line_assembler_top_macros.svh
`include "serial_line_assembler_top_macros.svh"
module sla_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sla_pkg::sla_push_t    push,
  output logic                  full2,
  output logic                  head_valid,
  output sla_pkg::sla_result_t  head,
  input  logic                  pop
);
  import sla_pkg::*;

  sla_result_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [FIFO_AW-1:0]   wr_ptr_p1;
  logic [FIFO_CW-1:0]   n_push;

  assign wr_ptr_p1  = wr_ptr_r + FIFO_AW'(1);
  assign n_push     = FIFO_CW'(push.push0) + FIFO_CW'(push.push1);
  assign full2      = count_r > FIFO_CW'(FIFO_DEPTH - 2);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + n_push - FIFO_CW'(pop);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  // checks
  `SLA_ASSERT(a_count_bound, count_r <= FIFO_CW'(FIFO_DEPTH))
  `SLA_ASSERT_IMP(a_no_push_when_full, full2, !push.push0)
  `SLA_ASSERT_IMP(a_no_pop_when_empty, !head_valid, !pop)
  `SLA_ASSERT(a_ptr_gap, (wr_ptr_r - rd_ptr_r) == count_r[FIFO_AW-1:0])

endmodule

// ===== sv/serial_line_assembler_top.sv =====
// top level of the serial line assembler
// depends on sla_pkg, sla_core and sla_fifo
//
// Splits received bytes into lines: each accepted item is a byte or a
// millisecond tick, and gives zero, one or two result items (a character,
// an end of line, or a character followed by an overflow end of line).
// One item is accepted per cycle while in_stall is low; the line state
// updates in the cycle of acceptance and its results enter a four-entry
// result queue, so a result is offered at the earliest on the cycle after
// its item is accepted. in_stall rises while fewer than two queue entries
// are free, which happens when results are taken more slowly than they are
// made, as while out_stall is held. Configuration is written through
// cfg_we, cfg_index and cfg_data by the user only while idle; the block
// does not enforce this.
module serial_line_assembler_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sla_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [7:0]                     out_char_byte,
  output logic [15:0]                    out_char_index,
  output logic [15:0]                    out_line_length,
  output logic [1:0]                     out_end_reason,
  output logic                           out_is_last
);
  import sla_pkg::*;

  sla_push_t   push;
  sla_result_t head;
  logic        full2;
  logic        acc;
  logic        pop;

  // handshakes
  assign in_stall = full2;
  assign acc      = in_valid && !full2;
  assign pop      = out_valid && !out_stall;

  sla_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .req_type  (in_req_type),
    .rx_byte   (in_rx_byte),
    .push      (push)
  );

  sla_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full2      (full2),
    .head_valid (out_valid),
    .head       (head),
    .pop        (pop)
  );

  // result fields
  assign out_kind        = head.kind;
  assign out_char_byte   = head.char_byte;
  assign out_char_index  = head.char_index;
  assign out_line_length = head.line_length;
  assign out_end_reason  = head.reason;
  assign out_is_last     = head.is_last;

endmodule
